// ===== src/fsvs_pkg.sv =====
`default_nettype none

package fsvs_pkg;

    localparam int PIX_W       = 8;
    localparam int INDEX_W     = 16;
    localparam int COLOUR_W    = 3 * PIX_W;
    localparam int SCORE_W     = 23;
    localparam int COORD_W     = 11;
    localparam int CFG_W       = 16;
    localparam int SIZE_W      = 12;
    localparam int MSK         = 3;

    // 9 taps of 8 bits: sum < 2^12, square < 2^16, sum of squares < 2^20
    localparam int SUM_W       = 12;
    localparam int SQ_W        = 16;
    localparam int SQSUM_W     = 20;

    localparam int FIRST_RESET  = 0;
    localparam int WIDTH_RESET  = 1388;
    localparam int HEIGHT_RESET = 1040;

    localparam int IN_TDATA_W  = 3 * PIX_W + INDEX_W;
    localparam int OUT_DATA_W  = 2 * COORD_W + INDEX_W + COLOUR_W;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        REG_FIRST_INDEX  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    // Which sides of the 3x3 window fall outside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } win_edge_t;

endpackage

`default_nettype wire

// ===== src/fsvs_ram.sv =====
`default_nettype none

module fsvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/fsvs_window.sv =====
`default_nettype none

module fsvs_window import fsvs_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int CB = $clog2(MAX_WIDTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [CB-1:0]      in_col,
    input  logic [PIX_W-1:0]   in_green,
    input  logic               in_write,
    input  win_edge_t          in_edge,
    output logic               out_valid,
    output logic [SCORE_W-1:0] out_score
);

    localparam int PAIR_W = 2 * PIX_W;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [CB-1:0]     col1_reg;
    logic [PIX_W-1:0]  green1_reg;
    logic              write1_reg;
    win_edge_t         edge1_reg, edge2_reg;
    logic              fwd_reg;
    logic [PAIR_W-1:0] fwd_pair_reg;

    logic [PAIR_W-1:0] line_rdata;
    logic [PAIR_W-1:0] pair_cur;
    logic [PAIR_W-1:0] pair_next;
    logic              line_we;

    logic [PIX_W-1:0]   win_reg [MSK][MSK];
    logic [PIX_W-1:0]   tap     [MSK][MSK];
    logic [SQ_W-1:0]    sq3_reg [MSK][MSK];
    logic [SUM_W-1:0]   sum3_reg, sum3_next;
    logic [SQSUM_W-1:0] sqsum4_reg, sqsum4_next;
    logic [SCORE_W-1:0] s2_4_reg;
    logic [2*SUM_W-1:0] s2_full;
    logic [SQSUM_W+3:0] nine_sq;
    logic [SQSUM_W+3:0] diff;
    logic [SCORE_W-1:0] score5_reg;

    // line buffer word: high byte = row above, low byte = two rows above
    assign pair_cur  = fwd_reg ? fwd_pair_reg : line_rdata;
    assign pair_next = {green1_reg, pair_cur[PAIR_W-1:PIX_W]};
    assign line_we   = v1_reg && write1_reg;

    fsvs_ram #(.WIDTH(PAIR_W), .DEPTH(2 ** CB)) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (col1_reg),
        .wdata (pair_next),
        .raddr (in_col),
        .rdata (line_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end else begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            // back-to-back beats on one column: the RAM read misses this write
            fwd_reg <= in_valid && line_we && (in_col == col1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        col1_reg     <= in_col;
        green1_reg   <= in_green;
        write1_reg   <= in_write;
        edge1_reg    <= in_edge;
        fwd_pair_reg <= pair_next;
        edge2_reg    <= edge1_reg;
        if (v1_reg) begin
            for (int k = 0; k < MSK; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= pair_cur[PIX_W-1:0];
            win_reg[1][2] <= pair_cur[PAIR_W-1:PIX_W];
            win_reg[2][2] <= green1_reg;
        end
    end

    // zero padding outside the frame
    always_comb begin
        sum3_next = '0;
        for (int k = 0; k < MSK; k++) begin
            for (int j = 0; j < MSK; j++) begin
                if ((k == 0 && edge2_reg.top) || (k == MSK - 1 && edge2_reg.bottom) ||
                    (j == 0 && edge2_reg.left) || (j == MSK - 1 && edge2_reg.right)) begin
                    tap[k][j] = '0;
                end else begin
                    tap[k][j] = win_reg[k][j];
                end
                sum3_next = sum3_next + SUM_W'(tap[k][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MSK; k++) begin
            for (int j = 0; j < MSK; j++) begin
                sq3_reg[k][j] <= SQ_W'(tap[k][j]) * SQ_W'(tap[k][j]);
            end
        end
        sum3_reg <= sum3_next;
    end

    always_comb begin
        sqsum4_next = '0;
        for (int k = 0; k < MSK; k++) begin
            for (int j = 0; j < MSK; j++) begin
                sqsum4_next = sqsum4_next + SQSUM_W'(sq3_reg[k][j]);
            end
        end
        s2_full = (2*SUM_W)'(sum3_reg) * (2*SUM_W)'(sum3_reg);
    end

    always_ff @(posedge aclk) begin
        sqsum4_reg <= sqsum4_next;
        s2_4_reg   <= s2_full[SCORE_W-1:0];
    end

    // 9*sum(g^2) - sum(g)^2
    assign nine_sq = {sqsum4_reg, 3'b000} + {4'b0000, sqsum4_reg};
    assign diff    = nine_sq - (SQSUM_W+4)'(s2_4_reg);

    always_ff @(posedge aclk) begin
        score5_reg <= diff[SCORE_W-1:0];
    end

    assign out_valid = v5_reg;
    assign out_score = score5_reg;

endmodule

`default_nettype wire

// ===== src/focus_stack_variance_select_top.sv =====
// A pixel's result is pushed once the beat W+1 beats after it (W = row width in use)
//   has passed the window, score pipeline and best-store read-modify-write. Throughput:
//   one beat per cycle while s_tready is high; line buffer, colour delay and best store
//   each take one read and one write per cycle. An 8-entry output queue absorbs m_tready
//   stalls. Reset: synchronous, active low; clears counters, valids and the queue, and
//   loads register defaults. Memories are not cleared and no clearing pass runs.
`default_nettype none

module focus_stack_variance_select_top import fsvs_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // red, green, blue, image_index
    input  logic [0:0]             s_tuser,   // flush
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // row, column, depth_index, best_red,
                                              // best_green, best_blue, zero pad
    output logic                   m_tlast,   // frame_last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int CB     = $clog2(MAX_WIDTH);
    localparam int RB     = $clog2(MAX_HEIGHT);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int PRW    = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST  = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
    localparam int PIPE   = 5;
    localparam int OFD    = 8;
    localparam int OFA    = $clog2(OFD);
    localparam int BEST_W = SCORE_W + INDEX_W + COLOUR_W;
    localparam int BA     = RB + CB;

    function automatic logic [CW-1:0] clamp_w(input logic [SIZE_W-1:0] v);
        if (v == '0) return CW'(1);
        else if (32'(v) > MAX_WIDTH) return CW'(MAX_WIDTH);
        else return CW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [SIZE_W-1:0] v);
        if (v == '0) return HW'(1);
        else if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
        else return HW'(v);
    endfunction

    // configuration
    logic [INDEX_W-1:0] first_index_reg;
    logic [CW-1:0]      w_reg;
    logic [HW-1:0]      h_reg;
    logic               cfg_fire;
    logic               restart;

    // input position and output position
    logic [CB-1:0]      pc_reg, pc_next;
    logic [PRW-1:0]     pr_reg, pr_next;
    logic [CW-1:0]      warm_reg, warm_next;
    logic               active_reg, active_next;
    logic [RB-1:0]      r_reg, r_next;
    logic [CB-1:0]      c_reg, c_next;
    logic [INDEX_W-1:0] fidx_reg, fidx0;

    logic               s_fire;
    logic               flush;
    logic               in_frame;
    logic               row_last, col_last, frame_last0;
    logic [PIX_W-1:0]   g_in;
    logic [COLOUR_W-1:0] colour_in;
    logic [COLOUR_W-1:0] colour_rdata;
    win_edge_t          edge0;

    // item pipeline
    logic               pv_reg     [1:PIPE];
    logic               pact_reg   [1:PIPE];
    logic               plast_reg  [1:PIPE];
    logic               pfirst_reg [1:PIPE];
    logic [INDEX_W-1:0] pidx_reg   [1:PIPE];
    logic [RB-1:0]      prow_reg   [1:PIPE];
    logic [CB-1:0]      pcol_reg   [1:PIPE];
    logic [COLOUR_W-1:0] pcolour_reg [2:PIPE];

    logic               win_valid;
    logic [SCORE_W-1:0] win_score;

    // best store
    logic [BEST_W-1:0]   best_rdata, best_wdata;
    logic [BA-1:0]       best_raddr, best_waddr;
    logic                best_we;
    logic                replace;
    logic [SCORE_W-1:0]  old_score;
    logic [INDEX_W-1:0]  old_idx, sel_idx;
    logic [COLOUR_W-1:0] old_colour, sel_colour;

    // output queue
    logic [OUT_DATA_W:0] ofifo_reg [OFD];
    logic [OUT_DATA_W:0] push_word;
    logic [OFA-1:0]      wptr_reg, rptr_reg;
    logic [OFA:0]        cnt_reg;
    logic [OFA:0]        busy;
    logic                push, pop;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && ((cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH) ||
                                    (cfg_reg_t'(cfg_index) == REG_IMAGE_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_index_reg <= INDEX_W'(FIRST_RESET);
            w_reg           <= CW'(W_RST);
            h_reg           <= HW'(H_RST);
        end else if (cfg_fire) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FIRST_INDEX:  first_index_reg <= cfg_data[INDEX_W-1:0];
                REG_IMAGE_WIDTH:  w_reg <= clamp_w(cfg_data[SIZE_W-1:0]);
                REG_IMAGE_HEIGHT: h_reg <= clamp_h(cfg_data[SIZE_W-1:0]);
                default: ;
            endcase
        end
    end

    assign s_fire    = s_tvalid && s_tready;
    assign flush     = s_tuser[0];
    assign in_frame  = 32'(pr_reg) < 32'(h_reg);
    assign row_last  = 32'(r_reg) == 32'(h_reg) - 1;
    assign col_last  = 32'(c_reg) == 32'(w_reg) - 1;
    assign frame_last0 = active_reg && row_last && col_last;
    assign fidx0     = (pr_reg == '0 && pc_reg == '0) ? s_tdata[IN_TDATA_W-1:3*PIX_W] : fidx_reg;
    assign g_in      = (in_frame && !flush) ? s_tdata[2*PIX_W-1:PIX_W] : '0;
    // colour word: red high, blue low
    assign colour_in = (in_frame && !flush) ?
                       {s_tdata[PIX_W-1:0], s_tdata[2*PIX_W-1:PIX_W], s_tdata[3*PIX_W-1:2*PIX_W]} :
                       '0;
    assign edge0.top    = (r_reg == '0);
    assign edge0.bottom = row_last;
    assign edge0.left   = (c_reg == '0);
    assign edge0.right  = col_last;

    always_comb begin
        pc_next     = pc_reg;
        pr_next     = pr_reg;
        warm_next   = warm_reg;
        active_next = active_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        if (s_fire) begin
            if (32'(pc_reg) == 32'(w_reg) - 1) begin
                pc_next = '0;
                pr_next = pr_reg + 1'b1;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
            if (!active_reg) begin
                // first window completes W+1 beats into the frame
                if (warm_reg == w_reg) begin
                    active_next = 1'b1;
                end else begin
                    warm_next = warm_reg + 1'b1;
                end
            end else if (frame_last0) begin
                pc_next     = '0;
                pr_next     = '0;
                warm_next   = '0;
                active_next = 1'b0;
                r_next      = '0;
                c_next      = '0;
            end else if (col_last) begin
                c_next = '0;
                r_next = r_reg + 1'b1;
            end else begin
                c_next = c_reg + 1'b1;
            end
        end
        if (restart) begin
            pc_next     = '0;
            pr_next     = '0;
            warm_next   = '0;
            active_next = 1'b0;
            r_next      = '0;
            c_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= '0;
            pr_reg     <= '0;
            warm_reg   <= '0;
            active_reg <= 1'b0;
            r_reg      <= '0;
            c_reg      <= '0;
            fidx_reg   <= '0;
        end else begin
            pc_reg     <= pc_next;
            pr_reg     <= pr_next;
            warm_reg   <= warm_next;
            active_reg <= active_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            if (s_fire) begin
                fidx_reg <= fidx0;
            end
        end
    end

    // two-row colour delay, written by input position, read by output position
    fsvs_ram #(.WIDTH(COLOUR_W), .DEPTH(2 ** (CB + 1))) u_colour_ram (
        .aclk  (aclk),
        .we    (s_fire && in_frame),
        .waddr ({pr_reg[0], pc_reg}),
        .wdata (colour_in),
        .raddr ({r_reg[0], c_reg}),
        .rdata (colour_rdata)
    );

    fsvs_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_fire),
        .in_col    (pc_reg),
        .in_green  (g_in),
        .in_write  (in_frame),
        .in_edge   (edge0),
        .out_valid (win_valid),
        .out_score (win_score)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= PIPE; i++) begin
                pv_reg[i] <= 1'b0;
            end
        end else begin
            pv_reg[1] <= s_fire;
            for (int i = 2; i <= PIPE; i++) begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pact_reg[1]   <= active_reg;
        plast_reg[1]  <= frame_last0;
        pfirst_reg[1] <= (fidx0 == first_index_reg);
        pidx_reg[1]   <= fidx0;
        prow_reg[1]   <= r_reg;
        pcol_reg[1]   <= c_reg;
        for (int i = 2; i <= PIPE; i++) begin
            pact_reg[i]   <= pact_reg[i-1];
            plast_reg[i]  <= plast_reg[i-1];
            pfirst_reg[i] <= pfirst_reg[i-1];
            pidx_reg[i]   <= pidx_reg[i-1];
            prow_reg[i]   <= prow_reg[i-1];
            pcol_reg[i]   <= pcol_reg[i-1];
        end
        pcolour_reg[2] <= colour_rdata;
        for (int i = 3; i <= PIPE; i++) begin
            pcolour_reg[i] <= pcolour_reg[i-1];
        end
    end

    // read the entry one stage ahead, compare and write back at the last stage
    assign best_raddr = {prow_reg[PIPE-1], pcol_reg[PIPE-1]};
    assign best_waddr = {prow_reg[PIPE], pcol_reg[PIPE]};
    assign {old_score, old_idx, old_colour} = best_rdata;
    assign replace    = pfirst_reg[PIPE] || (win_score > old_score);
    assign push       = win_valid && pact_reg[PIPE];
    assign best_we    = push && replace;
    assign best_wdata = {win_score, pidx_reg[PIPE], pcolour_reg[PIPE]};
    assign sel_idx    = replace ? pidx_reg[PIPE] : old_idx;
    assign sel_colour = replace ? pcolour_reg[PIPE] : old_colour;

    fsvs_ram #(.WIDTH(BEST_W), .DEPTH(2 ** BA)) u_best_ram (
        .aclk  (aclk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    assign push_word = {plast_reg[PIPE],
                        sel_colour[PIX_W-1:0],
                        sel_colour[2*PIX_W-1:PIX_W],
                        sel_colour[3*PIX_W-1:2*PIX_W],
                        sel_idx,
                        COORD_W'(pcol_reg[PIPE]),
                        COORD_W'(prow_reg[PIPE])};

    assign pop = m_tvalid && m_tready;

    // hold a slot in the queue for every beat still in the pipeline
    always_comb begin
        busy = cnt_reg;
        for (int i = 1; i <= PIPE; i++) begin
            busy = busy + (OFA+1)'(pv_reg[i]);
        end
    end

    assign s_tready = busy < (OFA+1)'(OFD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ofifo_reg[wptr_reg] <= push_word;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {{(OUT_TDATA_W-OUT_DATA_W){1'b0}}, ofifo_reg[rptr_reg][OUT_DATA_W-1:0]};
    assign m_tlast  = ofifo_reg[rptr_reg][OUT_DATA_W];

`ifndef SYNTHESIS
    a_queue_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(busy) <= OFD)
        else $error("queue credit exceeded");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (32'(cnt_reg) != OFD || pop))
        else $error("push into full queue");

    a_score_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        win_valid == pv_reg[PIPE])
        else $error("score out of step with item pipeline");

    a_best_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (pv_reg[PIPE-1] && pact_reg[PIPE-1] && best_we) |-> (best_raddr != best_waddr))
        else $error("best store read overlaps pending write");
`endif

endmodule

`default_nettype wire
